// ----- src/cld_pkg.sv -----
// Shared types and constants of the command line dispatcher.
`default_nettype none
package cld_pkg;

  // Input operation codes
  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_REG = 2'd1;
  localparam logic [1:0] OP_FWD = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ECHO     = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_REJECT   = 2'd2;

  // Characters
  localparam logic [7:0] CH_PCT = 8'd37;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_NUL = 8'd0;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [7:0] sender_pid;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] echo_code;
    logic [7:0] target_pid;
    logic       run_end;
  } out_word_t;

  // Commands handed from front to back
  typedef enum logic [2:0] {
    CODE_NONE,
    CODE_ECHO,
    CODE_CR,
    CODE_FWD,
    CODE_COMMIT,
    CODE_REJECT
  } code_t;

  typedef struct packed {
    code_t      code;
    logic [7:0] char_code;
    logic [7:0] pid;
    logic [3:0] plen;
  } cld_ctl_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ----- src/cld_front.sv -----
// Front end: edits lines, tracks registrations and classifies each word.
`default_nettype none
module cld_front #(
  parameter int LINE_LEN = 64,
  parameter int NUM_CMDS = 16,
  parameter int CMD_LEN  = 3,
  parameter int HEAD     = CMD_LEN + 2,
  parameter int DATA_W   = HEAD * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  cld_pkg::in_word_t      in_word,
  output logic                   push,
  output cld_pkg::cld_ctl_t      push_ctl,
  output logic [DATA_W-1:0]      push_data
);
  import cld_pkg::*;

  localparam int LW  = $clog2(LINE_LEN + 1);
  localparam int PW  = $clog2(CMD_LEN + 2);
  localparam int CW  = $clog2(NUM_CMDS + 1);

  logic [LW-1:0] elen_r, elen_nxt, flen_r, flen_nxt;
  logic [7:0]    ehead_r [HEAD], ehead_nxt [HEAD];
  logic [7:0]    fhead_r [HEAD], fhead_nxt [HEAD];
  logic [7:0]    stage_r [CMD_LEN], stage_nxt [CMD_LEN];
  logic [PW-1:0] pos_r, pos_nxt;
  logic          bad_r, bad_nxt, bad_now;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ok;

  // Classify the word and update line and registration state
  always_comb begin
    elen_nxt  = elen_r;
    flen_nxt  = flen_r;
    ehead_nxt = ehead_r;
    fhead_nxt = fhead_r;
    stage_nxt = stage_r;
    pos_nxt   = pos_r;
    bad_nxt   = bad_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_ctl  = '{code: CODE_NONE, char_code: in_word.char_code,
                  pid: in_word.sender_pid, plen: 4'(pos_r)};
    push_data = '0;
    bad_now   = bad_r;
    ok        = 1'b0;
    if (acc) begin
      case (in_word.op)
        OP_KEY: begin
          push = 1'b1;
          if (in_word.char_code == CH_CR) begin
            push_ctl.code = CODE_CR;
            for (int k = 0; k < HEAD; k++)
              push_data[k*8 +: 8] = (k < int'(elen_r)) ? ehead_r[k] : CH_NUL;
            elen_nxt = '0;
          end else begin
            push_ctl.code = CODE_ECHO;
            if (in_word.char_code == CH_BS || in_word.char_code == CH_DEL) begin
              if (elen_r != '0) elen_nxt = elen_r - 1'b1;
            end else if (int'(elen_r) < LINE_LEN) begin
              for (int k = 0; k < HEAD; k++)
                if (int'(elen_r) == k) ehead_nxt[k] = in_word.char_code;
              elen_nxt = elen_r + 1'b1;
            end
          end
        end
        OP_REG: begin
          if (pos_r == '0)
            bad_now = bad_r | (in_word.char_code != CH_PCT);
          else
            bad_now = bad_r | (in_word.char_code == CH_NUL) |
                      (int'(pos_r) > CMD_LEN);
          for (int j = 0; j < CMD_LEN; j++)
            if (int'(pos_r) == j + 1) stage_nxt[j] = in_word.char_code;
          if (in_word.last_char) begin
            ok = !bad_now && pos_r != '0 && int'(pos_r) <= CMD_LEN &&
                 int'(cnt_r) < NUM_CMDS;
            pos_nxt = '0;
            bad_nxt = 1'b0;
            push    = 1'b1;
            if (ok) begin
              push_ctl.code = CODE_COMMIT;
              for (int j = 0; j < CMD_LEN; j++) push_data[j*8 +: 8] = stage_nxt[j];
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              push_ctl.code = CODE_REJECT;
            end
          end else begin
            bad_nxt = bad_now;
            if (int'(pos_r) <= CMD_LEN) pos_nxt = pos_r + 1'b1;
          end
        end
        OP_FWD: begin
          if (int'(flen_r) < LINE_LEN) begin
            for (int k = 0; k < HEAD; k++)
              if (int'(flen_r) == k) fhead_nxt[k] = in_word.char_code;
            flen_nxt = flen_r + 1'b1;
          end
          if (in_word.last_char) begin
            push = 1'b1;
            push_ctl.code = CODE_FWD;
            for (int k = 0; k < HEAD; k++)
              push_data[k*8 +: 8] = (k < int'(flen_nxt)) ? fhead_nxt[k] : CH_NUL;
            flen_nxt = '0;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elen_r <= '0;
      flen_r <= '0;
      pos_r  <= '0;
      bad_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      elen_r <= elen_nxt;
      flen_r <= flen_nxt;
      pos_r  <= pos_nxt;
      bad_r  <= bad_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Line heads and id staging
  always_ff @(posedge clk) begin
    ehead_r <= ehead_nxt;
    fhead_r <= fhead_nxt;
    stage_r <= stage_nxt;
  end

endmodule
`default_nettype wire

// ----- src/cld_queue.sv -----
// Two-entry queue between front and back.
`default_nettype none
module cld_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  output logic              valid,
  output logic [W-1:0]      head_data,
  input  wire logic         pop
);
  logic [W-1:0] q_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full      = cnt_r == 2'd2;
  assign valid     = cnt_r != 2'd0;
  assign head_data = q_r[rp_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

// ----- src/cld_back.sv -----
// Back end: owns the command table, walks it for matches and emits results.
`default_nettype none
module cld_back #(
  parameter int NUM_CMDS = 16,
  parameter int CMD_LEN  = 3,
  parameter int HEAD     = CMD_LEN + 2,
  parameter int DATA_W   = HEAD * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  cld_pkg::cld_ctl_t      q_ctl,
  input  wire logic [DATA_W-1:0] q_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cld_pkg::out_word_t     out_word
);
  import cld_pkg::*;

  localparam int CW  = $clog2(NUM_CMDS + 1);
  localparam int IW  = (NUM_CMDS > 1) ? $clog2(NUM_CMDS) : 1;
  localparam int LNW = $clog2(CMD_LEN + 1);
  localparam int RW  = CMD_LEN * 8;

  back_state_t       state_r, state_nxt;
  cld_ctl_t          ctl_r;
  logic [DATA_W-1:0] data_r;
  logic [CW-1:0]     cnt_r, idx_r;
  logic [RW-1:0]     mem [NUM_CMDS];
  logic [RW-1:0]     rdata_r;
  logic [LNW-1:0]    lens_r [NUM_CMDS];
  logic [7:0]        owners_r [NUM_CMDS];
  logic              hit_r, out_valid_r;
  logic [7:0]        pid_r;
  logic [1:0]        step_r;
  out_word_t         out_word_r, res;
  logic              load, walk, cmp_hit, last_idx, commit;
  logic [LNW-1:0]    n;
  logic [7:0]        after;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign load      = state_r == B_OUT && !(ctl_r.code == CODE_FWD && !hit_r) &&
                     (!out_valid_r || !out_stall);
  assign walk      = data_r[7:0] == CH_PCT && cnt_r != '0;
  assign last_idx  = idx_r + 1'b1 == cnt_r;
  assign commit    = state_r == B_IDLE && q_valid && q_ctl.code == CODE_COMMIT;

  // Compare the fetched entry with the head of the line
  always_comb begin
    n       = lens_r[idx_r[IW-1:0]];
    cmp_hit = 1'b1;
    after   = CH_NUL;
    for (int j = 0; j < CMD_LEN; j++)
      if (j < int'(n) && rdata_r[j*8 +: 8] != data_r[(j+1)*8 +: 8]) cmp_hit = 1'b0;
    for (int k = 1; k <= CMD_LEN; k++)
      if (int'(n) == k) after = data_r[(k+1)*8 +: 8];
    cmp_hit = cmp_hit && (after == CH_NUL || after == CH_SP);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          if (q_ctl.code == CODE_CR || q_ctl.code == CODE_FWD) state_nxt = B_READ;
          else if (q_ctl.code != CODE_COMMIT) state_nxt = B_OUT;
        end
      end
      B_READ: begin
        if (walk) state_nxt = B_CMP;
        else state_nxt = B_OUT;
      end
      B_CMP: begin
        if (cmp_hit || last_idx) state_nxt = B_OUT;
        else state_nxt = B_READ;
      end
      B_OUT: begin
        if (ctl_r.code == CODE_FWD && !hit_r) state_nxt = B_IDLE;
        else if (load && res.run_end) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs: queue pop and the result for the current step
  always_comb begin
    pop = state_r == B_IDLE && q_valid;
    res = '{kind: KIND_ECHO, echo_code: 8'd0, target_pid: 8'd0, run_end: 1'b1};
    case (ctl_r.code)
      CODE_ECHO: res.echo_code = ctl_r.char_code;
      CODE_REJECT: res.kind = KIND_REJECT;
      CODE_CR: begin
        if (step_r == 2'd0) begin
          res.echo_code = CH_CR;
          res.run_end   = 1'b0;
        end else if (step_r == 2'd1) begin
          res.echo_code = CH_LF;
          res.run_end   = !hit_r;
        end else begin
          res.kind       = KIND_DISPATCH;
          res.target_pid = pid_r;
        end
      end
      default: begin
        res.kind       = KIND_DISPATCH;
        res.target_pid = pid_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) cnt_r <= cnt_r + 1'b1;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Entry, walk index, match result and output word
  always_ff @(posedge clk) begin
    if (pop) begin
      ctl_r  <= q_ctl;
      data_r <= q_data;
      step_r <= 2'd0;
      hit_r  <= 1'b0;
      idx_r  <= '0;
    end
    if (state_r == B_CMP) begin
      if (cmp_hit) begin
        hit_r <= 1'b1;
        pid_r <= owners_r[idx_r[IW-1:0]];
      end
      idx_r <= idx_r + 1'b1;
    end
    if (load) begin
      out_word_r <= res;
      step_r     <= step_r + 2'd1;
    end
  end

  // Table memory and per-entry fields
  always_ff @(posedge clk) begin
    if (commit) begin
      mem[cnt_r[IW-1:0]]      <= q_data[RW-1:0];
      lens_r[cnt_r[IW-1:0]]   <= LNW'(q_ctl.plen);
      owners_r[cnt_r[IW-1:0]] <= q_ctl.pid;
    end
    if (state_r == B_READ) rdata_r <= mem[idx_r[IW-1:0]];
  end

endmodule
`default_nettype wire

// ----- src/command_line_dispatcher.sv -----
// Top level of the command line dispatcher.
// Usage:
//   The input channel takes one character word per accepted transfer
//   (in_valid high, in_stall low): a keystroke, a registration character
//   or a forwarded command line character. The result channel presents
//   echo, dispatch and reject words on out_valid/out_word, held while
//   out_stall is high. run_end marks the last result of one input word.
// Flow:
//   A word passes the front end combinationally and enters a two-entry queue.
//   The back end takes one queued word at a time. An echo or reject word
//   passes the queue, the entry register and the output register. A carriage
//   return or the last forwarded character walks the command table, one memory
//   read and one compare per registered command, stopping at the first hit,
//   then emits its results one per cycle while out_stall is low.
// Reset:
//   Synchronous active-low reset empties the lines, the table and the queue.
// Stall:
//   A stalled result holds the back end; the queue fills and in_stall rises.
`default_nettype none
module command_line_dispatcher #(
  parameter int LINE_LEN = 64,
  parameter int NUM_CMDS = 16,
  parameter int CMD_LEN  = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  cld_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cld_pkg::out_word_t out_word
);
  import cld_pkg::*;

  localparam int HEAD   = CMD_LEN + 2;
  localparam int DATA_W = HEAD * 8;
  localparam int QW     = $bits(cld_ctl_t) + DATA_W;

  logic              push, q_full, q_valid, pop;
  cld_ctl_t          push_ctl, q_ctl;
  logic [DATA_W-1:0] push_data, q_data;
  logic [QW-1:0]     q_head;

  assign in_stall = q_full;
  assign q_ctl    = q_head[QW-1 -: $bits(cld_ctl_t)];
  assign q_data   = q_head[DATA_W-1:0];

  cld_front #(.LINE_LEN(LINE_LEN), .NUM_CMDS(NUM_CMDS), .CMD_LEN(CMD_LEN),
              .HEAD(HEAD), .DATA_W(DATA_W)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(in_valid && !q_full), .in_word(in_word),
    .push(push), .push_ctl(push_ctl), .push_data(push_data)
  );

  cld_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data({push_ctl, push_data}),
    .full(q_full), .valid(q_valid), .head_data(q_head), .pop(pop)
  );

  cld_back #(.NUM_CMDS(NUM_CMDS), .CMD_LEN(CMD_LEN), .HEAD(HEAD),
             .DATA_W(DATA_W)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ctl(q_ctl), .q_data(q_data),
    .pop(pop), .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

endmodule
`default_nettype wire

// ----- src/cld_checker.sv -----
// Port-level checks of the command line dispatcher and their binding.
`default_nettype none
module cld_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input cld_pkg::out_word_t out_word
);
  import cld_pkg::*;

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word)) else $error("result changed under stall");

  // Dispatch and reject words always close their run
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind != KIND_ECHO |-> out_word.run_end)
    else $error("non-echo word not last");

  // A CR echo never ends its run, so LF follows it
  a_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == KIND_ECHO && out_word.echo_code == CH_CR
    |-> !out_word.run_end) else $error("CR echo ends run");

  // Unused fields read as zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.kind == KIND_ECHO ? out_word.target_pid == 8'd0
                                              : out_word.echo_code == 8'd0))
    else $error("unused field nonzero");

endmodule

bind command_line_dispatcher cld_checker u_cld_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_word(out_word)
);
`default_nettype wire

// ----- verif/command_line_dispatcher_checker.sv -----
// Result checker for the command line dispatcher: predicts and compares words.
`timescale 1ns / 1ps
module command_line_dispatcher_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  cld_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  cld_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending_count
);
  import cld_pkg::*;

  localparam int LINE_LEN = 64;
  localparam int NUM_CMDS = 16;
  localparam int CMD_LEN  = 3;

  logic [7:0] edit_buf [LINE_LEN];
  int         edit_len;
  logic [7:0] fwd_buf [LINE_LEN];
  int         fwd_len;
  logic [7:0] cmd_chars [NUM_CMDS*CMD_LEN];
  int         cmd_lens [NUM_CMDS];
  logic [7:0] cmd_owner [NUM_CMDS];
  int         cmd_count;
  int         reg_pos;
  bit         reg_bad;

  out_word_t expected_words [$];

  assign pending_count = expected_words.size();

  // Character of a line, zero past its end.
  function automatic logic [7:0] line_char(bit fwd, int len, int p);
    if (p < len && p < LINE_LEN) return fwd ? fwd_buf[p] : edit_buf[p];
    return CH_NUL;
  endfunction

  // Walk the table in registration order; first hit wins.
  function automatic bit owner_lookup(bit fwd, int len, output logic [7:0] pid);
    bit same;
    logic [7:0] after;
    pid = 8'd0;
    if (line_char(fwd, len, 0) != CH_PCT) return 0;
    for (int i = 0; i < cmd_count; i++) begin
      same = 1;
      for (int j = 0; j < cmd_lens[i]; j++)
        if (line_char(fwd, len, j + 1) != cmd_chars[i*CMD_LEN + j]) same = 0;
      if (same) begin
        after = line_char(fwd, len, cmd_lens[i] + 1);
        if (after == CH_NUL || after == CH_SP) begin
          pid = cmd_owner[i];
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic out_word_t mk(logic [1:0] k, logic [7:0] e, logic [7:0] p, logic r);
    out_word_t w;
    w.kind = k; w.echo_code = e; w.target_pid = p; w.run_end = r;
    return w;
  endfunction

  // Advance the predicted state by one accepted word.
  task automatic predict_word(in_word_t w);
    logic [7:0] pid;
    bit hit;
    bit ok;
    case (w.op)
      OP_KEY: begin
        if (w.char_code == CH_CR) begin
          hit = owner_lookup(0, edit_len, pid);
          edit_len = 0;
          expected_words.push_back(mk(KIND_ECHO, CH_CR, 8'd0, 1'b0));
          expected_words.push_back(mk(KIND_ECHO, CH_LF, 8'd0, !hit));
          if (hit) expected_words.push_back(mk(KIND_DISPATCH, 8'd0, pid, 1'b1));
        end else begin
          expected_words.push_back(mk(KIND_ECHO, w.char_code, 8'd0, 1'b1));
          if (w.char_code == CH_BS || w.char_code == CH_DEL) begin
            if (edit_len > 0) edit_len--;
          end else if (edit_len < LINE_LEN) begin
            edit_buf[edit_len] = w.char_code;
            edit_len++;
          end
        end
      end
      OP_REG: begin
        if (reg_pos == 0) begin
          if (w.char_code != CH_PCT) reg_bad = 1;
        end else if (w.char_code == CH_NUL || reg_pos > CMD_LEN) begin
          reg_bad = 1;
        end else if (cmd_count < NUM_CMDS) begin
          cmd_chars[cmd_count*CMD_LEN + reg_pos - 1] = w.char_code;
        end
        if (w.last_char) begin
          ok = !reg_bad && reg_pos >= 1 && reg_pos <= CMD_LEN && cmd_count < NUM_CMDS;
          if (ok) begin
            cmd_lens[cmd_count] = reg_pos;
            cmd_owner[cmd_count] = w.sender_pid;
            cmd_count++;
          end else begin
            expected_words.push_back(mk(KIND_REJECT, 8'd0, 8'd0, 1'b1));
          end
          reg_pos = 0;
          reg_bad = 0;
        end else if (reg_pos <= CMD_LEN) begin
          reg_pos++;
        end
      end
      OP_FWD: begin
        if (fwd_len < LINE_LEN) begin
          fwd_buf[fwd_len] = w.char_code;
          fwd_len++;
        end
        if (w.last_char) begin
          hit = owner_lookup(1, fwd_len, pid);
          fwd_len = 0;
          if (hit) expected_words.push_back(mk(KIND_DISPATCH, 8'd0, pid, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      edit_len = 0; fwd_len = 0; cmd_count = 0; reg_pos = 0; reg_bad = 0;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word %h", out_word);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word.kind !== exp_w.kind || out_word.echo_code !== exp_w.echo_code ||
              out_word.target_pid !== exp_w.target_pid ||
              out_word.run_end !== exp_w.run_end) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected kind %0d echo %h pid %h end %b, got kind %0d echo %h pid %h end %b",
                       exp_w.kind, exp_w.echo_code, exp_w.target_pid, exp_w.run_end,
                       out_word.kind, out_word.echo_code, out_word.target_pid,
                       out_word.run_end);
          end
        end
      end
      if (in_valid && !in_stall) predict_word(in_word);
    end
  end
endmodule

// ----- verif/command_line_dispatcher_tb.sv -----
// Testbench top for the command line dispatcher: stimulus and verdict.
`timescale 1ns / 1ps
module command_line_dispatcher_tb;
  import cld_pkg::*;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_word_t out_word;
  int        fail_count;
  int        pending_count;
  int        cycle_count = 0;
  bit        idle_on = 1;
  bit        hold_off = 0;
  bit        hold_done = 0;

  command_line_dispatcher uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
  );

  command_line_dispatcher_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word), .fail_count(fail_count), .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stall: random idling, or a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= idle_on && ($urandom_range(99) < 36);
  end

  // Offer one word and wait for it to be taken; valid stays up for the next one.
  task automatic send_word(logic [1:0] op, logic [7:0] c, logic [7:0] pid, logic last);
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_word.op <= op;
    in_word.char_code <= c;
    in_word.sender_pid <= pid;
    in_word.last_char <= last;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Register an id: a percent sign, then its characters.
  task automatic register_id(string id, logic [7:0] pid);
    send_word(OP_REG, CH_PCT, pid, id.len() == 0);
    for (int i = 0; i < id.len(); i++)
      send_word(OP_REG, id[i], pid, i == id.len() - 1);
  endtask

  // Type a line: on the keystroke path then CR, or on the forwarded path with the last character marked.
  task automatic line_word(logic [1:0] op, string s);
    for (int i = 0; i < s.len(); i++)
      send_word(op, s[i], 8'($urandom), op == OP_FWD && i == s.len() - 1);
    if (op == OP_KEY) send_word(OP_KEY, CH_CR, 8'd0, 0);
  endtask

  function automatic logic [7:0] id_char();
    case ($urandom_range(3))
      0: return "a";
      1: return "b";
      2: return "c";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int n;
    string s;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: registrations, matches, edits, rejects.
    register_id("ab", 8'hff);
    register_id("x", 8'h00);
    line_word(OP_KEY, "%ab");
    line_word(OP_FWD, "%x go");
    send_word(OP_KEY, "%", 0, 0);
    send_word(OP_KEY, "x", 0, 0);
    send_word(OP_KEY, "q", 0, 0);
    send_word(OP_KEY, CH_BS, 0, 0);
    send_word(OP_KEY, CH_DEL, 0, 0);
    send_word(OP_KEY, CH_DEL, 0, 0);
    send_word(OP_KEY, CH_CR, 0, 0);
    send_word(OP_KEY, CH_CR, 0, 0);
    send_word(OP_REG, "a", 1, 1);
    register_id("", 2);
    register_id("abcd", 3);
    send_word(OP_REG, CH_PCT, 4, 0);
    send_word(OP_REG, CH_NUL, 4, 1);
    send_word(OP_FWD, 8'hff, 8'hff, 1);
    send_word(2'd3, 8'hff, 8'hff, 1);
    send_word(OP_FWD, "%", 0, 0);
    send_word(OP_FWD, "x", 0, 0);
    send_word(OP_FWD, CH_NUL, 0, 1);

    // Random: mostly well-formed sequences with random content.
    n = 0;
    while (n < 400) begin
      if (n >= 150 && n < 220) idle_on = 0;
      else idle_on = 1;
      case ($urandom_range(9))
        0, 1: begin
          s = "";
          repeat ($urandom_range(3, 1)) s = {s, string'(id_char())};
          register_id(s, 8'($urandom));
          n += s.len() + 1;
        end
        2, 3, 4, 5: begin
          s = "%";
          repeat ($urandom_range(3, 1)) s = {s, string'(id_char())};
          if ($urandom_range(1)) s = {s, " z"};
          line_word($urandom_range(1) ? OP_KEY : OP_FWD, s);
          n += s.len() + 1;
        end
        6: begin
          repeat ($urandom_range(70, 1)) begin
            send_word(OP_KEY, $urandom_range(1) ? id_char() : CH_BS, 0, 0);
            n++;
          end
          send_word(OP_KEY, CH_CR, 0, 0);
          n++;
        end
        7: begin
          if ($urandom_range(3) == 0) begin
            repeat (68) send_word(OP_FWD, id_char(), 0, 0);
            n += 68;
          end
          send_word(OP_FWD, 8'($urandom), 8'($urandom), 1);
          n++;
        end
        default: begin
          send_word(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                    1'($urandom_range(1)));
          n++;
        end
      endcase
      // Long receiver hold-off while the sender keeps going.
      if (n > 250 && !hold_done) begin
        hold_done = 1;
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk);
            hold_off = 0;
          end
        join_none
        for (int i = 0; i < 12; i++) send_word(OP_KEY, id_char(), 0, 0);
        n += 12;
      end
    end

    in_valid <= 0;
    idle_on = 1;
    wait (!hold_off);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
